[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/lrmp_pkg.sv]
// ----------------------------------------------------------------------------
// lrmp_pkg
// Constants, types and helpers of the modular linear recurrence block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrmp_pkg;

  localparam int unsigned VAL_W           = 30;
  localparam int unsigned INDEX_WIDTH_DEF = 63;
  localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
  localparam logic [63:0] MU_FULL         = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] MU              = MU_FULL[30:0];

  localparam int unsigned MAT_N     = 9;
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned RAM_DEPTH = MAT_N * NUM_SLOTS;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  typedef enum logic [1:0] {
    REG_COEF_PREV  = 2'd0,
    REG_COEF_PREV2 = 2'd1,
    REG_COEF_CONST = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BSEL_RAM,
    BSEL_S2,
    BSEL_S1,
    BSEL_ONE
  } bsel_t;

  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic              vec;
    logic [RAM_AW-1:0] dst;
    bsel_t             bsel;
  } tag_t;

  function automatic logic [VAL_W-1:0] red_once(input logic [VAL_W:0] x);
    logic [VAL_W:0] d;
    begin
      d = x - {1'b0, PRIME};
      red_once = (x >= {1'b0, PRIME}) ? d[VAL_W-1:0] : x[VAL_W-1:0];
    end
  endfunction

  function automatic logic [RAM_AW-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [1:0] row,
                                                  input logic [1:0] col);
    begin
      slot_addr = RAM_AW'(slot) * RAM_AW'(9) + RAM_AW'(row) * RAM_AW'(3) + RAM_AW'(col);
    end
  endfunction

endpackage

`default_nettype wire

[hdl/lrmp_ram.sv]
// ----------------------------------------------------------------------------
// lrmp_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrmp_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hdl/linear_recurrence_mod_prime_core.sv]
// Flow: an index of two or below goes from the input transfer to ST_FINISH, which loads out_valid
//   once any held output is taken; larger indices first run ST_INIT and the matrix products.
// Throughput: one transfer at a time; each 3x3 product issues 27 products to one
//   pipelined modular multiplier that reads operands from a small RAM.
// Reset: synchronous, resets control state and clears the coefficient registers to zero.
// ----------------------------------------------------------------------------
// linear_recurrence_mod_prime_core
// Matrix power of the affine recurrence companion matrix modulo 1000000007.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module linear_recurrence_mod_prime_core #(
  parameter int unsigned INDEX_WIDTH = lrmp_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [lrmp_pkg::VAL_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [INDEX_WIDTH-1:0]     in_term_index,
  input  wire logic [lrmp_pkg::VAL_W-1:0] in_seed_first,
  input  wire logic [lrmp_pkg::VAL_W-1:0] in_seed_second,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [lrmp_pkg::VAL_W-1:0] out_term_value
);

  import lrmp_pkg::*;

  localparam int unsigned LAT       = 6;
  localparam int unsigned INIT_LAST = 2 * MAT_N - 1;
  localparam int unsigned INIT_W    = $clog2(2 * MAT_N);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_SQ,
    OP_VEC
  } op_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [INDEX_WIDTH-1:0] power_r, power_nxt;
  logic [INIT_W-1:0]      init_cnt_r, init_cnt_nxt;
  logic [1:0]             i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [SLOT_W-1:0]      a_slot_r, a_slot_nxt, b_slot_r, b_slot_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]       out_term_value_r, out_term_value_nxt;
  logic [VAL_W-1:0]       coef_prev_r, coef_prev2_r, coef_const_r;
  tag_t                   tag_r [LAT];
  tag_t                   tag_issue;

  logic [VAL_W-1:0]       s1_r, s2_r, res_r, accsum_r;
  logic [2*VAL_W-1:0]     prod_r, prod2_r;
  logic [VAL_W:0]         q_r;
  logic [31:0]            r3_r, r4_r;
  logic [VAL_W-1:0]       r5_r;

  logic [VAL_W-1:0]       rd_a, rd_b, opb, init_data, acc_red;
  logic [RAM_AW-1:0]      raddr_a, raddr_b, waddr;
  logic [VAL_W-1:0]       wdata;
  logic                   we, acc_wr, pipe_busy, in_acc;
  logic [SLOT_W-1:0]      dest_slot, l_slot;
  logic [VAL_W:0]         acc_sum;
  logic [61:0]            q_full;
  logic [60:0]            qp_full;
  logic [31:0]            r3_sub, r4_sub;

  assign in_stall       = (state_r != ST_IDLE) || !rst_n;
  assign out_valid      = out_valid_r;
  assign out_term_value = out_term_value_r;
  assign in_acc         = in_valid && !in_stall;

  always_comb begin
    dest_slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (SLOT_W'(s) != a_slot_r && SLOT_W'(s) != b_slot_r) begin
        dest_slot = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    pipe_busy = 1'b0;
    for (int p = 0; p < LAT; p++) begin
      pipe_busy = pipe_busy | tag_r[p].vld;
    end
  end

  always_comb begin
    l_slot          = (op_r == OP_SQ) ? b_slot_r : a_slot_r;
    raddr_a         = slot_addr(l_slot, i_r, k_r);
    raddr_b         = slot_addr(b_slot_r, k_r, j_r);
    tag_issue.vld   = (state_r == ST_ISSUE);
    tag_issue.first = (k_r == 2'd0);
    tag_issue.last  = (k_r == 2'd2);
    tag_issue.vec   = (op_r == OP_VEC);
    tag_issue.dst   = slot_addr(dest_slot, i_r, j_r);
    if (op_r != OP_VEC) begin
      tag_issue.bsel = BSEL_RAM;
    end else if (k_r == 2'd0) begin
      tag_issue.bsel = BSEL_S2;
    end else if (k_r == 2'd1) begin
      tag_issue.bsel = BSEL_S1;
    end else begin
      tag_issue.bsel = BSEL_ONE;
    end
  end

  always_comb begin
    case (init_cnt_r)
      INIT_W'(0), INIT_W'(4), INIT_W'(8): init_data = VAL_W'(1);
      INIT_W'(9):  init_data = red_once({1'b0, coef_prev_r});
      INIT_W'(10): init_data = red_once({1'b0, coef_prev2_r});
      INIT_W'(11): init_data = red_once({1'b0, coef_const_r});
      INIT_W'(12), INIT_W'(17): init_data = VAL_W'(1);
      default: init_data = '0;
    endcase
  end

  always_comb begin
    acc_sum = (tag_r[LAT-1].first ? '0 : {1'b0, accsum_r}) + {1'b0, r5_r};
    acc_red = red_once(acc_sum);
    acc_wr  = tag_r[LAT-1].vld && tag_r[LAT-1].last;
    if (state_r == ST_INIT) begin
      we    = 1'b1;
      waddr = RAM_AW'(init_cnt_r);
      wdata = init_data;
    end else begin
      we    = acc_wr && !tag_r[LAT-1].vec;
      waddr = tag_r[LAT-1].dst;
      wdata = acc_red;
    end
  end

  lrmp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RAM_DEPTH)
  ) u_mat_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    power_nxt          = power_r;
    init_cnt_nxt       = init_cnt_r;
    i_nxt              = i_r;
    j_nxt              = j_r;
    k_nxt              = k_r;
    a_slot_nxt         = a_slot_r;
    b_slot_nxt         = b_slot_r;
    out_valid_nxt      = out_valid_r;
    out_term_value_nxt = out_term_value_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_term_index[INDEX_WIDTH-1:1] == '0 ||
              in_term_index == INDEX_WIDTH'(2)) begin
            state_nxt = ST_FINISH;
          end else begin
            power_nxt    = in_term_index - INDEX_WIDTH'(2);
            init_cnt_nxt = '0;
            state_nxt    = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        init_cnt_nxt = init_cnt_r + INIT_W'(1);
        if (init_cnt_r == INIT_W'(INIT_LAST)) begin
          a_slot_nxt = SLOT_W'(0);
          b_slot_nxt = SLOT_W'(1);
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        i_nxt     = '0;
        j_nxt     = '0;
        k_nxt     = '0;
        state_nxt = ST_ISSUE;
        if (power_r == '0) begin
          op_nxt = OP_VEC;
        end else if (power_r[0]) begin
          op_nxt = OP_ACC;
        end else begin
          op_nxt = OP_SQ;
        end
      end
      ST_ISSUE: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt = '0;
          j_nxt = j_r + 2'd1;
          if (j_r == 2'd2) begin
            j_nxt = '0;
            i_nxt = i_r + 2'd1;
          end
          if (op_r == OP_VEC || (i_r == 2'd2 && j_r == 2'd2)) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          case (op_r)
            OP_ACC: begin
              a_slot_nxt = dest_slot;
              state_nxt  = ST_ISSUE;
              if (power_r[INDEX_WIDTH-1:1] != '0) begin
                op_nxt = OP_SQ;
              end else begin
                power_nxt = '0;
                op_nxt    = OP_VEC;
              end
            end
            OP_SQ: begin
              b_slot_nxt = dest_slot;
              power_nxt  = power_r >> 1;
              state_nxt  = ST_CHECK;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_term_value_nxt = res_r;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      op_r          <= OP_ACC;
      power_r       <= '0;
      init_cnt_r    <= '0;
      i_r           <= '0;
      j_r           <= '0;
      k_r           <= '0;
      a_slot_r      <= SLOT_W'(0);
      b_slot_r      <= SLOT_W'(1);
      out_valid_r   <= 1'b0;
      coef_prev_r   <= '0;
      coef_prev2_r  <= '0;
      coef_const_r  <= '0;
      for (int p = 0; p < LAT; p++) begin
        tag_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      power_r     <= power_nxt;
      init_cnt_r  <= init_cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      a_slot_r    <= a_slot_nxt;
      b_slot_r    <= b_slot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_PREV:  coef_prev_r  <= cfg_wdata;
          REG_COEF_PREV2: coef_prev2_r <= cfg_wdata;
          REG_COEF_CONST: coef_const_r <= cfg_wdata;
          default: ;
        endcase
      end
      tag_r[0] <= tag_issue;
      for (int p = 1; p < LAT; p++) begin
        tag_r[p] <= tag_r[p-1];
      end
    end
    out_term_value_r <= out_term_value_nxt;
  end

  always_comb begin
    case (tag_r[0].bsel)
      BSEL_S2:  opb = s2_r;
      BSEL_S1:  opb = s1_r;
      BSEL_ONE: opb = VAL_W'(1);
      default:  opb = rd_b;
    endcase
    q_full  = 62'(prod_r[59:29]) * 62'(MU);
    qp_full = 61'(q_r) * 61'(PRIME);
    r3_sub  = r3_r - 32'(PRIME);
    r4_sub  = r4_r - 32'(PRIME);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= red_once({1'b0, in_seed_first});
      s2_r <= red_once({1'b0, in_seed_second});
      if (in_term_index[INDEX_WIDTH-1:1] == '0) begin
        res_r <= red_once({1'b0, in_seed_first});
      end else begin
        res_r <= red_once({1'b0, in_seed_second});
      end
    end else if (acc_wr && tag_r[LAT-1].vec) begin
      res_r <= acc_red;
    end
    if (tag_r[LAT-1].vld) begin
      accsum_r <= acc_red;
    end
    prod_r  <= 60'(rd_a) * 60'(opb);
    prod2_r <= prod_r;
    q_r     <= q_full[61:31];
    r3_r    <= prod2_r[31:0] - qp_full[31:0];
    r4_r    <= (r3_r >= 32'(PRIME)) ? r3_sub : r3_r;
    r5_r    <= (r4_r >= 32'(PRIME)) ? r4_sub[VAL_W-1:0] : r4_r[VAL_W-1:0];
  end

  `ASSERT_ALWAYS(a_slot_distinct, a_slot_r != b_slot_r)
  `ASSERT_IMPLIES(mul_result_reduced, tag_r[LAT-1].vld, r5_r < PRIME)
  `ASSERT_IMPLIES(pipe_only_in_product, pipe_busy,
                  state_r == ST_ISSUE || state_r == ST_DRAIN)
  `ASSERT_NEXT(finish_loads_output, state_r == ST_FINISH && !out_valid_r, out_valid_r)

endmodule

`default_nettype wire
